>>> rtl/lit_pkg.sv
// Shared widths and result status codes of the linear interpolation table.
package lit_pkg;

  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = 7;

  localparam logic [STATUS_W-1:0] ST_INTERP   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOW      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HIGH     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

endpackage

>>> rtl/linear_interp_table_top.sv
// Piecewise linear interpolation breakpoint table with an iterative divider.
//
// The block stores up to TABLE_DEPTH breakpoints in signed fixed point with FRAC_BITS fraction
// bits and handles one beat at a time; in_ready is high only while no item is in work. An
// append reads the last entry, divides for the slope with a restoring divider that produces
// one slope quotient bit per cycle, saturates the slope and writes the entry; an append to the
// first slot skips the divider, and a refused append to a full table goes straight to the
// result. A lookup clamps low or high against the first and last entries, else walks the
// table memory one entry per cycle over its single read port, then multiplies and adds; an
// empty table goes straight to the result. A finished result waits in the output register,
// and the next beat is accepted meanwhile.
module linear_interp_table_top #(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_func,
  input  logic signed [lit_pkg::DATA_W-1:0]    in_x,
  input  logic signed [lit_pkg::DATA_W-1:0]    in_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lit_pkg::DATA_W-1:0]    out_value_out,
  output logic        [lit_pkg::STATUS_W-1:0]  out_status,
  output logic        [lit_pkg::ENTRY_W-1:0]   out_entries_used
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int DW     = lit_pkg::DATA_W;
  localparam int DEN_W  = DW + 1;
  localparam int NUM_W  = DEN_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(NUM_W);
  localparam int PROD_W = DW + DEN_W;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_AP_RD    = 12'b0000_0000_0010,
    S_AP_SETUP = 12'b0000_0000_0100,
    S_AP_DIV   = 12'b0000_0000_1000,
    S_AP_SAT   = 12'b0000_0001_0000,
    S_AP_WR    = 12'b0000_0010_0000,
    S_LK_FIRST = 12'b0000_0100_0000,
    S_LK_LAST  = 12'b0000_1000_0000,
    S_LK_WALK  = 12'b0001_0000_0000,
    S_LK_MUL   = 12'b0010_0000_0000,
    S_LK_FIN   = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_value_r, out_value_nxt;
  logic [lit_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [lit_pkg::ENTRY_W-1:0] out_entries_r, out_entries_nxt;

  logic signed [DW-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic signed [DW-1:0] lo_x_r, lo_x_nxt, lo_y_r, lo_y_nxt;
  logic signed [DW-1:0] slope_r, slope_nxt;
  logic signed [DEN_W-1:0] dist_r, dist_nxt, dx_r, dx_nxt, dy_r, dy_nxt;
  logic [DEN_W-1:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic neg_r, neg_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [DW-1:0] res_value_r, res_value_nxt;
  logic [lit_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  logic signed [DW-1:0] mem_x [TABLE_DEPTH];
  logic signed [DW-1:0] mem_y [TABLE_DEPTH];
  logic signed [DW-1:0] mem_s [TABLE_DEPTH];
  logic signed [DW-1:0] rd_x_r, rd_y_r, rd_s_r;
  logic [ADDR_W-1:0] rd_addr;
  logic mem_we;

  logic [CNT_W-1:0] cnt_m1;
  logic table_full, table_empty, out_free;
  logic signed [DEN_W-1:0] dx_c, dy_c, dist_c;
  logic [DEN_W-1:0] dx_mag, dy_mag;
  logic [DEN_W:0] rem_sh, rem_sub;
  logic rem_ge;
  logic [DW-1:0] slope_sat;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [DW-1:0] prod_sat;
  logic signed [DEN_W-1:0] sum_c;
  logic signed [DW-1:0] sum_sat;

  assign cnt_m1      = cnt_r - CNT_W'(1);
  assign table_full  = (cnt_r == CNT_W'(TABLE_DEPTH));
  assign table_empty = (cnt_r == '0);
  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (state_r == S_IDLE);
  assign mem_we      = (state_r == S_AP_WR);

  assign dx_c   = DEN_W'(qx_r) - DEN_W'(rd_x_r);
  assign dy_c   = DEN_W'(qy_r) - DEN_W'(rd_y_r);
  assign dist_c = DEN_W'(qx_r) - DEN_W'(lo_x_r);
  assign dx_mag = dx_r[DEN_W-1] ? DEN_W'(-dx_r) : DEN_W'(dx_r);
  assign dy_mag = dy_r[DEN_W-1] ? DEN_W'(-dy_r) : DEN_W'(dy_r);

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign rem_ge  = (rem_sh >= {1'b0, den_r});

  always_comb begin
    if (quo_r[NUM_W-1:DW-1] != '0) begin
      slope_sat = neg_r ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      slope_sat = neg_r ? DW'(-quo_r[DW-1:0]) : quo_r[DW-1:0];
    end
  end

  assign prod_sh = prod_r >>> FRAC_BITS;
  always_comb begin
    if (prod_sh[PROD_W-1:DW-1] == '0 || prod_sh[PROD_W-1:DW-1] == '1) begin
      prod_sat = prod_sh[DW-1:0];
    end else begin
      prod_sat = prod_sh[PROD_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

  assign sum_c = DEN_W'(lo_y_r) + DEN_W'(prod_sat);
  always_comb begin
    if (sum_c[DEN_W-1] != sum_c[DW-1]) begin
      sum_sat = sum_c[DEN_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      sum_sat = sum_c[DW-1:0];
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:     rd_addr = (in_func == lit_pkg::FUNC_LOOKUP) ? '0 : cnt_m1[ADDR_W-1:0];
      S_LK_FIRST: rd_addr = cnt_m1[ADDR_W-1:0];
      S_LK_LAST:  rd_addr = ADDR_W'(1);
      S_LK_WALK:  rd_addr = idx_r + ADDR_W'(1);
      default:    rd_addr = '0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_value_nxt   = out_value_r;
    out_status_nxt  = out_status_r;
    out_entries_nxt = out_entries_r;
    qx_nxt          = qx_r;
    qy_nxt          = qy_r;
    lo_x_nxt        = lo_x_r;
    lo_y_nxt        = lo_y_r;
    slope_nxt       = slope_r;
    dist_nxt        = dist_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    den_nxt         = den_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    neg_nxt         = neg_r;
    dcnt_nxt        = dcnt_r;
    idx_nxt         = idx_r;
    prod_nxt        = prod_r;
    res_value_nxt   = res_value_r;
    res_status_nxt  = res_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          qx_nxt        = in_x;
          qy_nxt        = in_y;
          res_value_nxt = '0;
          if (in_func == lit_pkg::FUNC_APPEND) begin
            if (table_full) begin
              res_status_nxt = lit_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else if (table_empty) begin
              slope_nxt = '0;
              state_nxt = S_AP_WR;
            end else begin
              state_nxt = S_AP_RD;
            end
          end else begin
            if (table_empty) begin
              res_status_nxt = lit_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_LK_FIRST;
            end
          end
        end
      end
      S_AP_RD: begin
        dx_nxt    = dx_c;
        dy_nxt    = dy_c;
        state_nxt = S_AP_SETUP;
      end
      S_AP_SETUP: begin
        if (dx_r == '0) begin
          slope_nxt = '0;
          state_nxt = S_AP_WR;
        end else begin
          den_nxt   = dx_mag;
          quo_nxt   = NUM_W'(dy_mag) << FRAC_BITS;
          rem_nxt   = '0;
          neg_nxt   = dx_r[DEN_W-1] ^ dy_r[DEN_W-1];
          dcnt_nxt  = DCNT_W'(NUM_W - 1);
          state_nxt = S_AP_DIV;
        end
      end
      S_AP_DIV: begin
        rem_nxt  = rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo_nxt  = {quo_r[NUM_W-2:0], rem_ge};
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == '0) begin
          state_nxt = S_AP_SAT;
        end
      end
      S_AP_SAT: begin
        slope_nxt = slope_sat;
        state_nxt = S_AP_WR;
      end
      S_AP_WR: begin
        cnt_nxt        = cnt_r + CNT_W'(1);
        res_status_nxt = lit_pkg::ST_APPENDED;
        state_nxt      = S_DONE;
      end
      S_LK_FIRST: begin
        if (qx_r <= rd_x_r) begin
          res_value_nxt  = rd_y_r;
          res_status_nxt = lit_pkg::ST_LOW;
          state_nxt      = S_DONE;
        end else begin
          lo_x_nxt  = rd_x_r;
          lo_y_nxt  = rd_y_r;
          state_nxt = S_LK_LAST;
        end
      end
      S_LK_LAST: begin
        if (qx_r >= rd_x_r) begin
          res_value_nxt  = rd_y_r;
          res_status_nxt = lit_pkg::ST_HIGH;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = ADDR_W'(1);
          state_nxt = S_LK_WALK;
        end
      end
      S_LK_WALK: begin
        if (qx_r <= rd_x_r) begin
          slope_nxt = rd_s_r;
          dist_nxt  = dist_c;
          state_nxt = S_LK_MUL;
        end else begin
          lo_x_nxt = rd_x_r;
          lo_y_nxt = rd_y_r;
          idx_nxt  = idx_r + ADDR_W'(1);
        end
      end
      S_LK_MUL: begin
        prod_nxt  = PROD_W'(slope_r) * PROD_W'(dist_r);
        state_nxt = S_LK_FIN;
      end
      S_LK_FIN: begin
        res_value_nxt  = sum_sat;
        res_status_nxt = lit_pkg::ST_INTERP;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_value_nxt   = res_value_r;
          out_status_nxt  = res_status_r;
          out_entries_nxt = lit_pkg::ENTRY_W'(cnt_r);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[cnt_r[ADDR_W-1:0]] <= qx_r;
      mem_y[cnt_r[ADDR_W-1:0]] <= qy_r;
      mem_s[cnt_r[ADDR_W-1:0]] <= slope_r;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
    rd_s_r <= mem_s[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r   <= out_value_nxt;
    out_status_r  <= out_status_nxt;
    out_entries_r <= out_entries_nxt;
    qx_r          <= qx_nxt;
    qy_r          <= qy_nxt;
    lo_x_r        <= lo_x_nxt;
    lo_y_r        <= lo_y_nxt;
    slope_r       <= slope_nxt;
    dist_r        <= dist_nxt;
    dx_r          <= dx_nxt;
    dy_r          <= dy_nxt;
    den_r         <= den_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    neg_r         <= neg_nxt;
    dcnt_r        <= dcnt_nxt;
    idx_r         <= idx_nxt;
    prod_r        <= prod_nxt;
    res_value_r   <= res_value_nxt;
    res_status_r  <= res_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_value_out    = out_value_r;
  assign out_status       = out_status_r;
  assign out_entries_used = out_entries_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("Point count exceeds the table depth.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A new beat was offered ready right after an accepted beat.");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AP_WR) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("A stored point did not advance the point count.");

  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_AP_WR) |=> $stable(cnt_r))
    else $error("Point count changed without a stored point.");
`endif

endmodule
